### src/acs_pkg.sv
// Shared types and constants for the accumulator CPU step block.
// Holds opcodes, status and flag codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package acs_pkg;

    localparam int DATA_W        = 32;
    localparam int BYTE_W        = 8;
    localparam int PC_W          = 9;
    localparam int STATUS_W      = 3;
    localparam int FLAG_W        = 2;
    localparam int KIND_W        = 2;
    localparam int DIV_CNT_W     = $clog2(DATA_W);
    localparam int MEM_DEPTH_DEF = 256;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXEC  = 2'd2;

    localparam logic [BYTE_W-1:0] OP_LOAD  = 8'h01;
    localparam logic [BYTE_W-1:0] OP_STORE = 8'h02;
    localparam logic [BYTE_W-1:0] OP_ADD   = 8'h03;
    localparam logic [BYTE_W-1:0] OP_SUB   = 8'h04;
    localparam logic [BYTE_W-1:0] OP_MUL   = 8'h05;
    localparam logic [BYTE_W-1:0] OP_DIV   = 8'h06;
    localparam logic [BYTE_W-1:0] OP_JMP   = 8'h07;
    localparam logic [BYTE_W-1:0] OP_CMP   = 8'h08;
    localparam logic [BYTE_W-1:0] OP_HLT   = 8'hFF;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALTED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FETCH_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OPND_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_OPCODE  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_STOPPED     = 3'd6;

    localparam logic [FLAG_W-1:0] FLAG_NONE    = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_ZERO    = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_GREATER = 2'd2;

    typedef enum logic [2:0] {
        ACC_NONE = 3'd0,
        ACC_ADD  = 3'd1,
        ACC_SUB  = 3'd2,
        ACC_MUL  = 3'd3,
        ACC_DIV  = 3'd4,
        ACC_LOAD = 3'd5,
        ACC_CMP  = 3'd6
    } acc_op_t;

    typedef struct packed {
        logic                latch_in;
        logic                mem_rd_pc;
        logic                mem_rd_item;
        logic                mem_wr_item;
        logic                mem_wr_store;
        logic                rdata_cap;
        logic                opc_load;
        logic                pc_inc;
        logic                pc_jump;
        acc_op_t             acc_op;
        logic                div_start;
        logic                stop;
        logic                status_we;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              stopped;
        logic              pc_oob;
        logic [BYTE_W-1:0] mem_byte;
        logic              opnd_oob;
        logic [BYTE_W-1:0] opc;
        logic              b_zero;
        logic              div_done;
        logic              out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### src/acs_if.sv
// Handshake channel interfaces for the input and result transactions.
// Depends on acs_pkg for field widths.
`default_nettype none

interface acs_in_if;
    import acs_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    modport source (output valid, kind, mem_addr, mem_wdata, input ready);
    modport sink (input valid, kind, mem_addr, mem_wdata, output ready);
endinterface

interface acs_out_if;
    import acs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [BYTE_W-1:0]        opcode;
    logic [PC_W-1:0]          prog_counter;
    logic signed [DATA_W-1:0] accumulator;
    logic [FLAG_W-1:0]        flag_value;
    logic [BYTE_W-1:0]        mem_rdata;

    modport source (
        output valid, status, opcode, prog_counter, accumulator, flag_value, mem_rdata,
        input  ready
    );
    modport sink (
        input  valid, status, opcode, prog_counter, accumulator, flag_value, mem_rdata,
        output ready
    );
endinterface

`default_nettype wire

### src/acs_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating to zero.
// Depends on acs_pkg for widths.
`default_nettype none

module acs_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [acs_pkg::DATA_W-1:0] dividend,
    input  wire logic [acs_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [acs_pkg::DATA_W-1:0]     quotient
);
    import acs_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    ub_reg;
    logic                 neg_reg;
    logic [DATA_W:0]      trial;

    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, ub_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            quo_reg <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            ub_reg  <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

### src/acs_dp.sv
// Datapath: byte memory, program counter, accumulator, flag, operand register,
// divider and result register. Depends on acs_pkg and acs_div.
`default_nettype none

module acs_dp #(
    parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic signed [acs_pkg::DATA_W-1:0] cfg_wdata,
    input  wire logic [acs_pkg::KIND_W-1:0]       item_kind,
    input  wire logic [acs_pkg::BYTE_W-1:0]       item_addr,
    input  wire logic [acs_pkg::BYTE_W-1:0]       item_wdata,
    input  wire acs_pkg::ctrl_cmd_t               cmd,
    output acs_pkg::dp_stat_t                     stat,
    input  wire logic                             res_ready,
    output logic                                  res_valid,
    output logic [acs_pkg::STATUS_W-1:0]          res_status,
    output logic [acs_pkg::BYTE_W-1:0]            res_opcode,
    output logic [acs_pkg::PC_W-1:0]              res_prog_counter,
    output logic signed [acs_pkg::DATA_W-1:0]     res_accumulator,
    output logic [acs_pkg::FLAG_W-1:0]            res_flag_value,
    output logic [acs_pkg::BYTE_W-1:0]            res_mem_rdata
);
    import acs_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [PC_W-1:0] DEPTH_LIM = PC_W'(MEM_DEPTH);

    logic [BYTE_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [BYTE_W-1:0]   addr_reg;
    logic [BYTE_W-1:0]   wdata_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [DATA_W-1:0]   acc_reg;
    logic [DATA_W-1:0]   b_reg;
    logic [FLAG_W-1:0]   flag_reg;
    logic                stopped_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [BYTE_W-1:0]   opc_reg;
    logic [BYTE_W-1:0]   rdata_reg;
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                rd_ok_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BYTE_W-1:0]   out_opc_reg;
    logic [PC_W-1:0]     out_pc_reg;
    logic [DATA_W-1:0]   out_acc_reg;
    logic [FLAG_W-1:0]   out_flag_reg;
    logic [BYTE_W-1:0]   out_rdata_reg;

    logic [PC_W-1:0]   rd_addr;
    logic              rd_en;
    logic              rd_inrange;
    logic              item_inrange;
    logic              wr_en;
    logic [AW-1:0]     wr_idx;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] mem_byte;
    logic [DATA_W-1:0] arith;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    assign mem_byte     = rd_ok_reg ? rd_data_reg : '0;
    assign rd_en        = cmd.mem_rd_pc | cmd.mem_rd_item;
    assign rd_addr      = cmd.mem_rd_pc ? pc_reg : {1'b0, addr_reg};
    assign rd_inrange   = rd_addr < DEPTH_LIM;
    assign item_inrange = {1'b0, addr_reg} < DEPTH_LIM;
    assign wr_en        = (cmd.mem_wr_item & item_inrange) | cmd.mem_wr_store;
    assign wr_idx       = cmd.mem_wr_store ? mem_byte[AW-1:0] : addr_reg[AW-1:0];
    assign wr_data      = cmd.mem_wr_store ? acc_reg[BYTE_W-1:0] : wdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= rd_inrange && vld_reg[rd_addr[AW-1:0]];
            end
        end
    end

    acs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        case (cmd.acc_op)
            ACC_ADD:  arith = acc_reg + b_reg;
            ACC_SUB:  arith = acc_reg - b_reg;
            ACC_MUL:  arith = acc_reg * b_reg;
            ACC_DIV:  arith = div_q;
            default:  arith = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            acc_reg     <= '0;
            b_reg       <= '0;
            flag_reg    <= FLAG_NONE;
            stopped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                b_reg <= cfg_wdata;
            end
            if (cmd.pc_inc)
            begin
                pc_reg <= pc_reg + 1'b1;
            end
            else if (cmd.pc_jump)
            begin
                pc_reg <= {1'b0, mem_byte};
            end
            if (cmd.stop)
            begin
                stopped_reg <= 1'b1;
            end
            case (cmd.acc_op)
                ACC_ADD, ACC_SUB, ACC_MUL, ACC_DIV:
                begin
                    acc_reg  <= arith;
                    flag_reg <= (arith == '0) ? FLAG_ZERO : FLAG_NONE;
                end
                ACC_LOAD:
                begin
                    acc_reg <= {{(DATA_W-BYTE_W){1'b0}}, mem_byte};
                end
                ACC_CMP:
                begin
                    if (acc_reg == b_reg)
                    begin
                        flag_reg <= FLAG_ZERO;
                    end
                    else if ($signed(acc_reg) > $signed(b_reg))
                    begin
                        flag_reg <= FLAG_GREATER;
                    end
                    else
                    begin
                        flag_reg <= FLAG_NONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg   <= item_kind;
            addr_reg   <= item_addr;
            wdata_reg  <= item_wdata;
            status_reg <= ST_OK;
            opc_reg    <= '0;
            rdata_reg  <= '0;
        end
        else
        begin
            if (cmd.status_we)
            begin
                status_reg <= cmd.st_code;
            end
            if (cmd.opc_load)
            begin
                opc_reg <= mem_byte;
            end
            if (cmd.rdata_cap)
            begin
                rdata_reg <= mem_byte;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_opc_reg    <= opc_reg;
            out_pc_reg     <= pc_reg;
            out_acc_reg    <= acc_reg;
            out_flag_reg   <= flag_reg;
            out_rdata_reg  <= rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.stopped  = stopped_reg;
    assign stat.pc_oob   = pc_reg >= DEPTH_LIM;
    assign stat.mem_byte = mem_byte;
    assign stat.opnd_oob = {1'b0, mem_byte} >= DEPTH_LIM;
    assign stat.opc      = opc_reg;
    assign stat.b_zero   = b_reg == '0;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || res_ready;

    assign res_valid        = out_valid_reg;
    assign res_status       = out_status_reg;
    assign res_opcode       = out_opc_reg;
    assign res_prog_counter = out_pc_reg;
    assign res_accumulator  = out_acc_reg;
    assign res_flag_value   = out_flag_reg;
    assign res_mem_rdata    = out_rdata_reg;

endmodule

`default_nettype wire

### src/acs_ctrl.sv
// Controller state machine: sequences memory items and instruction execution.
// Depends on acs_pkg; drives acs_dp through the command struct.
`default_nettype none

module acs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire acs_pkg::dp_stat_t stat,
    output acs_pkg::ctrl_cmd_t     cmd
);
    import acs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_DISPATCH = 8'b00000010,
        S_RDATA    = 8'b00000100,
        S_DECODE   = 8'b00001000,
        S_OPER     = 8'b00010000,
        S_OPDONE   = 8'b00100000,
        S_DIV      = 8'b01000000,
        S_RESP     = 8'b10000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.status_we = 1'b1;
                cmd.st_code   = stat.stopped ? ST_STOPPED : ST_OK;
                state_next    = S_RESP;
                case (stat.kind)
                    KIND_WRITE:
                    begin
                        cmd.mem_wr_item = 1'b1;
                    end
                    KIND_READ:
                    begin
                        cmd.mem_rd_item = 1'b1;
                        state_next      = S_RDATA;
                    end
                    KIND_EXEC:
                    begin
                        if (!stat.stopped)
                        begin
                            if (stat.pc_oob)
                            begin
                                cmd.stop    = 1'b1;
                                cmd.st_code = ST_FETCH_RANGE;
                            end
                            else
                            begin
                                cmd.mem_rd_pc = 1'b1;
                                state_next    = S_DECODE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RDATA:
            begin
                cmd.rdata_cap = 1'b1;
                state_next    = S_RESP;
            end
            S_DECODE:
            begin
                cmd.opc_load = 1'b1;
                cmd.pc_inc   = 1'b1;
                state_next   = S_RESP;
                case (stat.mem_byte)
                    OP_LOAD, OP_STORE, OP_JMP:
                    begin
                        state_next = S_OPER;
                    end
                    OP_ADD:
                    begin
                        cmd.acc_op = ACC_ADD;
                    end
                    OP_SUB:
                    begin
                        cmd.acc_op = ACC_SUB;
                    end
                    OP_MUL:
                    begin
                        cmd.acc_op = ACC_MUL;
                    end
                    OP_CMP:
                    begin
                        cmd.acc_op = ACC_CMP;
                    end
                    OP_DIV:
                    begin
                        if (stat.b_zero)
                        begin
                            cmd.stop      = 1'b1;
                            cmd.status_we = 1'b1;
                            cmd.st_code   = ST_DIV_ZERO;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    OP_HLT:
                    begin
                        cmd.stop      = 1'b1;
                        cmd.status_we = 1'b1;
                        cmd.st_code   = ST_HALTED;
                    end
                    default:
                    begin
                        cmd.stop      = 1'b1;
                        cmd.status_we = 1'b1;
                        cmd.st_code   = ST_BAD_OPCODE;
                    end
                endcase
            end
            S_OPER:
            begin
                if (stat.pc_oob)
                begin
                    cmd.stop      = 1'b1;
                    cmd.status_we = 1'b1;
                    cmd.st_code   = ST_OPND_RANGE;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.mem_rd_pc = 1'b1;
                    state_next    = S_OPDONE;
                end
            end
            S_OPDONE:
            begin
                state_next = S_RESP;
                case (stat.opc)
                    OP_LOAD:
                    begin
                        cmd.acc_op = ACC_LOAD;
                        cmd.pc_inc = 1'b1;
                    end
                    OP_STORE:
                    begin
                        if (stat.opnd_oob)
                        begin
                            cmd.stop      = 1'b1;
                            cmd.status_we = 1'b1;
                            cmd.st_code   = ST_OPND_RANGE;
                        end
                        else
                        begin
                            cmd.mem_wr_store = 1'b1;
                            cmd.pc_inc       = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.pc_jump = 1'b1;
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.acc_op = ACC_DIV;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/accumulator_cpu_step.sv
// Top level of the accumulator CPU step block: joins controller and datapath.
// Depends on acs_pkg, acs_if, acs_ctrl and acs_dp.
//
//   Channel   Direction  Transfer                     Payload
//   in_ch     sink       valid & ready                kind, mem_addr, mem_wdata
//   out_ch    source     valid & ready                status .. mem_rdata
//   cfg       write      cfg_we at clock edge         cfg_wdata (operand_b)
//
// One transaction at a time; ready is high only while the controller is idle. A write, unused
// kind, stopped execute or fetch fault passes dispatch then response; a read adds a data capture
// state; an execute passes dispatch, decode and response, load, store and jump add operand fetch
// and operand done states, and a divide waits for the divider, which makes one quotient bit per cycle.
// A result waits in the output register; the next transaction stalls in its last state until that
// result is taken. Reset clears the memory's valid bits at once, so unwritten bytes read as zero.
`default_nettype none

module accumulator_cpu_step #(
    parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic signed [acs_pkg::DATA_W-1:0] cfg_wdata,
    acs_in_if.sink                                 in_ch,
    acs_out_if.source                              out_ch
);
    import acs_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    acs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_ch.valid),
        .item_ready (in_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    acs_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .item_kind        (in_ch.kind),
        .item_addr        (in_ch.mem_addr),
        .item_wdata       (in_ch.mem_wdata),
        .cmd              (cmd),
        .stat             (stat),
        .res_ready        (out_ch.ready),
        .res_valid        (out_ch.valid),
        .res_status       (out_ch.status),
        .res_opcode       (out_ch.opcode),
        .res_prog_counter (out_ch.prog_counter),
        .res_accumulator  (out_ch.accumulator),
        .res_flag_value   (out_ch.flag_value),
        .res_mem_rdata    (out_ch.mem_rdata)
    );

endmodule

`default_nettype wire
